// ===== hdl/u8dfa_pkg.sv =====
// shared types, constants and lookup tables of the utf-8 dfa decoder
// no dependencies
package u8dfa_pkg;

    localparam int BYTE_W       = 8;
    localparam int CLASS_W      = 4;
    localparam int STATE_W      = 4;
    localparam int CODE_W       = 21;
    localparam int NUM_STATES   = 9;
    localparam int NUM_CLASSES  = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int OUT_DATA_W   = 32;
    localparam int OUT_USER_W   = 3;

    localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
    localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
    localparam logic [STATE_W-1:0] ST_LAST   = 4'd8;

    localparam logic [BYTE_W-1:0] LEAD_MASK = 8'hff;
    localparam logic [5:0]        CONT_MASK = 6'h3f;

    // one classified item between front and back
    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [CLASS_W-1:0] byte_cls;
        logic               start_of_string;
        logic               last_of_string;
    } item_t;

    // flat transition table, indexed by state * 16 + class
    localparam logic [STATE_W-1:0] NEXT_STATE [NUM_STATES*NUM_CLASSES] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
        4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
    };

    function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
        logic [CLASS_W-1:0] c;
        case (b) inside
            [8'h00:8'h7f]: c = 4'd0;
            [8'h80:8'h8f]: c = 4'd1;
            [8'h90:8'h9f]: c = 4'd9;
            [8'ha0:8'hbf]: c = 4'd7;
            [8'hc0:8'hc1]: c = 4'd8;
            [8'hc2:8'hdf]: c = 4'd2;
            8'he0:         c = 4'd10;
            8'hed:         c = 4'd4;
            [8'he1:8'hef]: c = 4'd3;
            8'hf0:         c = 4'd11;
            [8'hf1:8'hf3]: c = 4'd6;
            8'hf4:         c = 4'd5;
            default:       c = 4'd8;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/u8dfa_front.sv =====
// front end: accepts bytes, looks up the character class, registers the item
// depends on u8dfa_pkg
module u8dfa_front
    import u8dfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        item_valid,
    input  logic        item_ready,
    output item_t       item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.data_byte       <= s_tdata;
            item_reg.byte_cls        <= byte_class(s_tdata);
            item_reg.start_of_string <= s_tuser;
            item_reg.last_of_string  <= s_tlast;
        end
    end

endmodule

// ===== hdl/u8dfa_queue.sv =====
// short fifo of classified items between front and back
// depends on u8dfa_pkg
module u8dfa_queue
    import u8dfa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // fill level tracks the pointer distance
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != CNT_FULL) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue count disagrees with pointers");

endmodule

// ===== hdl/u8dfa_back.sv =====
// back end: dfa step, code point accumulation and output register
// depends on u8dfa_pkg
module u8dfa_back
    import u8dfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    logic [STATE_W-1:0] state_reg, state_next;
    logic [CODE_W-1:0]  acc_reg, acc_next;
    logic               out_valid_reg;
    logic [STATE_W-1:0] out_state_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic               out_last_reg;
    logic [STATE_W-1:0] cur;
    logic [BYTE_W-1:0]  lead_bits;
    logic               step;

    assign item_ready = !out_valid_reg || m_tready;
    assign step       = item_valid && item_ready;

    always_comb
    begin
        cur = item.start_of_string ? ST_ACCEPT : state_reg;
        if (cur > ST_LAST)
        begin
            cur = ST_REJECT;
        end
        lead_bits = (LEAD_MASK >> item.byte_cls) & item.data_byte;
        if (cur != ST_ACCEPT)
        begin
            acc_next = {acc_reg[CODE_W-7:0], item.data_byte[5:0] & CONT_MASK};
        end
        else
        begin
            acc_next = {{(CODE_W-BYTE_W){1'b0}}, lead_bits};
        end
        state_next = NEXT_STATE[{cur, item.byte_cls}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                state_reg <= state_next;
                acc_reg   <= acc_next;
            end
            if (item_ready)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_state_reg <= state_next;
            out_code_reg  <= acc_next;
            out_last_reg  <= item.last_of_string;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-STATE_W-CODE_W){1'b0}}, out_code_reg, out_state_reg};
    assign m_tuser  = {out_last_reg && (out_state_reg == ST_ACCEPT),
                       out_state_reg == ST_REJECT,
                       out_state_reg == ST_ACCEPT};

    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= ST_LAST)
        else $error("dfa state out of range");

    // reject holds until a start flag arrives
    a_reject_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && state_reg == ST_REJECT && !item.start_of_string) |=> state_reg == ST_REJECT)
        else $error("reject state left without start flag");

    // output register mirrors the dfa state of the last step
    a_out_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (out_state_reg == state_reg && out_code_reg == acc_reg))
        else $error("output register out of step with dfa");

endmodule

// ===== hdl/utf8_dfa_decoder.sv =====
// utf-8 dfa decoder: one byte per item, one result per item
// a byte passes front register, queue and output register before its result is offered
// throughput: one byte per cycle unless stalled; dfa state and accumulator update together
// a four-entry queue (default depth) lets front and back stall independently
// reset (rst_n low, asynchronous): dfa in accept, accumulator zero, all buffers empty
// depends on u8dfa_pkg, u8dfa_front, u8dfa_queue, u8dfa_back
module utf8_dfa_decoder
    import u8dfa_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // data_byte
    input  logic [0:0]            s_axis_tuser,   // start_of_string
    input  logic                  s_axis_tlast,   // last_of_string
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // dfa_state[3:0], code_point[24:4], zeros
    output logic [OUT_USER_W-1:0] m_axis_tuser    // string_valid, rejected, accepted
);

    logic  f_valid, f_ready;
    item_t f_item;
    logic  q_valid, q_ready;
    item_t q_item;

    u8dfa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tuser    (s_axis_tuser[0]),
        .s_tlast    (s_axis_tlast),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    u8dfa_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    u8dfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser)
    );

endmodule
